// ===== hw/rtl/can_id_range_acceptance_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAN_ID_RANGE_ACCEPTANCE_FILTER_CORE_MACROS_SVH
`define CAN_ID_RANGE_ACCEPTANCE_FILTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIDF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cidf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CIDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cidf assertion failed");

`endif

// ===== hw/rtl/cidf_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN ID range filter package
// Sizes, codes and the token type that walks the slot chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cidf_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int ID_W      = 29;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

  typedef enum logic [1:0] {
    KIND_CHECK  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_PROBE  = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic            vld;
    cell_op_e        op;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    logic            hit;
    logic            done;
  } token_t;

endpackage

// ===== hw/rtl/cidf_if.sv =====
// ----------------------------------------------------------------------------
// CAN ID range filter channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cidf_in_if;
  import cidf_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [ID_W-1:0]  frame_id;
  logic [LEN_W-1:0] frame_length;
  logic [ID_W-1:0]  range_low;
  logic [ID_W-1:0]  range_high;

  modport source (output valid, kind, frame_id, frame_length, range_low, range_high,
                  input ready);
  modport sink (input valid, kind, frame_id, frame_length, range_low, range_high,
                output ready);
endinterface

interface cidf_out_if;
  logic       valid;
  logic       ready;
  logic       accept;
  logic [1:0] status;
  logic       flush_queue;

  modport source (output valid, accept, status, flush_queue, input ready);
  modport sink (input valid, accept, status, flush_queue, output ready);
endinterface

// ===== hw/rtl/cidf_cell.sv =====
// ----------------------------------------------------------------------------
// CAN ID range filter cell
// Holds one range slot and updates the token passing through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidf_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cidf_pkg::token_t tok_i,
  output cidf_pkg::token_t tok_o
);
  import cidf_pkg::*;

  logic            valid_q;
  logic [ID_W-1:0] low_q;
  logic [ID_W-1:0] high_q;
  token_t          tok_q;
  token_t          tok_d;
  logic            covered;
  logic            exact;
  logic            wr_set;
  logic            wr_clr;

  assign covered = valid_q && (tok_i.lo >= low_q) && (tok_i.hi <= high_q);
  assign exact   = valid_q && (tok_i.lo == low_q) && (tok_i.hi == high_q);

  always_comb begin
    tok_d  = tok_i;
    wr_set = 1'b0;
    wr_clr = 1'b0;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        CELL_PROBE: begin
          tok_d.hit = tok_i.hit | covered;
        end
        CELL_INSERT: begin
          if (!valid_q && !tok_i.done) begin
            wr_set     = 1'b1;
            tok_d.done = 1'b1;
          end
        end
        CELL_REMOVE: begin
          if (exact && !tok_i.done) begin
            wr_clr     = 1'b1;
            tok_d.done = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_set) begin
        valid_q <= 1'b1;
      end else if (wr_clr) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_set) begin
      low_q  <= tok_i.lo;
      high_q <= tok_i.hi;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/can_id_range_acceptance_filter_core.sv =====
// Checks and removes walk the slot chain once; an add not covered by a stored range walks
// it twice. Invalid ranges, unused kinds and checks on an empty table skip the chain and
// go straight to the emit state. Input ready returns in the same cycle as the result
// enters the output register. The token stepping one cell per cycle sets the walk time.
// Reset clears every slot valid bit and token register, the filter count, the state and the output valid flag.
// ----------------------------------------------------------------------------
// CAN ID range acceptance filter core
// Controller and chain of slot cells for range checks, adds and removes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_id_range_acceptance_filter_core (
  input logic clk_i,
  input logic rst_ni,
  cidf_in_if.sink    in_i,
  cidf_out_if.source out_o
);
  import cidf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  kind_e      kind_q, kind_d;
  logic       len_ok_q, len_ok_d;
  logic       res_accept_q, res_accept_d;
  status_e    res_status_q, res_status_d;
  logic       res_flush_q, res_flush_d;
  logic       out_vld_q, out_vld_d;
  logic       out_accept_q;
  status_e    out_status_q;
  logic       out_flush_q;
  logic       in_fire;
  logic       out_free;
  token_t     head;
  token_t     tok [NUM_SLOTS+1];
  token_t     tail;

  assign in_i.ready = rst_ni && (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign tok[0]     = head;
  assign tail       = tok[NUM_SLOTS];

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    cidf_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    kind_d       = kind_q;
    len_ok_d     = len_ok_q;
    res_accept_d = res_accept_q;
    res_status_d = res_status_q;
    res_flush_d  = res_flush_q;
    head         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_d       = kind_e'(in_i.kind);
          len_ok_d     = (in_i.frame_length >= MIN_LEN) && (in_i.frame_length <= MAX_LEN);
          res_accept_d = 1'b0;
          res_status_d = ST_OK;
          res_flush_d  = 1'b0;
          case (kind_e'(in_i.kind))
            KIND_CHECK: begin
              if (cnt_q == '0) begin
                res_accept_d = 1'b1;
                state_d      = S_EMIT;
              end else begin
                head.vld = 1'b1;
                head.op  = CELL_PROBE;
                head.lo  = in_i.frame_id;
                head.hi  = in_i.frame_id;
                state_d  = S_WALK;
              end
            end
            KIND_ADD, KIND_REMOVE: begin
              if (in_i.range_low > in_i.range_high) begin
                res_status_d = ST_INVALID;
                state_d      = S_EMIT;
              end else begin
                head.vld = 1'b1;
                head.op  = (kind_e'(in_i.kind) == KIND_ADD) ? CELL_PROBE : CELL_REMOVE;
                head.lo  = in_i.range_low;
                head.hi  = in_i.range_high;
                state_d  = S_WALK;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_WALK: begin
        if (tail.vld) begin
          case (tail.op)
            CELL_PROBE: begin
              if (kind_q == KIND_CHECK) begin
                res_accept_d = tail.hit && len_ok_q;
                state_d      = S_EMIT;
              end else if (tail.hit) begin
                state_d = S_EMIT;
              end else begin
                head      = tail;
                head.op   = CELL_INSERT;
                head.hit  = 1'b0;
                head.done = 1'b0;
              end
            end
            CELL_INSERT: begin
              if (tail.done) begin
                cnt_d       = cnt_q + CNT_W'(1);
                res_flush_d = 1'b1;
              end else begin
                res_status_d = ST_FULL;
              end
              state_d = S_EMIT;
            end
            CELL_REMOVE: begin
              if (tail.done) begin
                cnt_d = cnt_q - CNT_W'(1);
              end
              res_flush_d = 1'b1;
              state_d     = S_EMIT;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if ((state_q == S_EMIT) && out_free) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    len_ok_q     <= len_ok_d;
    res_accept_q <= res_accept_d;
    res_status_q <= res_status_d;
    res_flush_q  <= res_flush_d;
    if ((state_q == S_EMIT) && out_free) begin
      out_accept_q <= res_accept_q;
      out_status_q <= res_status_q;
      out_flush_q  <= res_flush_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.accept      = out_accept_q;
  assign out_o.status      = out_status_q;
  assign out_o.flush_queue = out_flush_q;

endmodule

// ===== hw/rtl/cidf_checker.sv =====
// ----------------------------------------------------------------------------
// CAN ID range filter checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "can_id_range_acceptance_filter_core_macros.svh"

module cidf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_accept_i,
  input logic [1:0] out_status_i,
  input logic       out_flush_i
);
  import cidf_pkg::*;

  `CIDF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_accept_i) && $stable(out_flush_i))
  `CIDF_ASSERT_NEXT(a_one_word_in_flight, in_valid_i && in_ready_i, !in_ready_i)
  `CIDF_ASSERT_IMPL(a_accept_plain, out_valid_i && out_accept_i, (out_status_i == ST_OK) && !out_flush_i)
  `CIDF_ASSERT_IMPL(a_invalid_no_flush, out_valid_i && (out_status_i == ST_INVALID), !out_flush_i && !out_accept_i)

endmodule

bind can_id_range_acceptance_filter_core cidf_checker u_cidf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_accept_i(out_o.accept),
  .out_status_i(out_o.status),
  .out_flush_i (out_o.flush_queue)
);
